### rtl/gcr_etd_pkg.sv
package gcr_etd_pkg;

    localparam int PACKET_BITS = 21;
    localparam int RUN_W = 5;
    localparam logic [15:0] BIT_PERIOD_RESET = 16'd100;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FRAME    = 2'd1,
        ST_CHECKSUM = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RANGE,
        S_DIV,
        S_APPLY,
        S_PAD,
        S_FIN
    } t_back_state;

    // One classified edge as it travels from the front to the back.
    typedef struct packed {
        logic [31:0] edge_time;
        logic        last_edge;
        logic        is_ref;
    } t_edge_item;

    typedef struct packed {
        t_back_state      state;
        logic [RUN_W-1:0] bits_taken;
    } t_back_stat;

    // GCR 5-bit code to nibble; codes that are not valid GCR map to zero.
    function automatic logic [3:0] gcr_nibble(input logic [4:0] code);
        logic [3:0] nib;
        case (code)
            5'd9:    nib = 4'd9;
            5'd10:   nib = 4'd10;
            5'd11:   nib = 4'd11;
            5'd13:   nib = 4'd13;
            5'd14:   nib = 4'd14;
            5'd15:   nib = 4'd15;
            5'd18:   nib = 4'd2;
            5'd19:   nib = 4'd3;
            5'd21:   nib = 4'd5;
            5'd22:   nib = 4'd6;
            5'd23:   nib = 4'd7;
            5'd26:   nib = 4'd8;
            5'd27:   nib = 4'd1;
            5'd29:   nib = 4'd4;
            5'd30:   nib = 4'd12;
            default: nib = 4'd0;
        endcase
        return nib;
    endfunction

    // Shift a run of length run (one followed by run-1 zeros) into the word.
    function automatic logic [PACKET_BITS-1:0] shift_run(
        input logic [PACKET_BITS-1:0] word,
        input logic [RUN_W-1:0]       run
    );
        logic [PACKET_BITS-1:0] res;
        res = (word << run) | (PACKET_BITS'(1) << (run - RUN_W'(1)));
        return res;
    endfunction

endpackage

### rtl/gcr_etd_front.sv
module gcr_etd_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  logic [31:0]             i_edge_time,
    input  logic                    i_last_edge,
    input  logic                    i_q_full,
    output logic                    o_ready,
    output logic                    o_push,
    output gcr_etd_pkg::t_edge_item o_item
);

    logic r_have_ref;
    logic n_have_ref;

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;

    // The first edge of a capture is the timing reference; the last edge ends it.
    always_comb begin
        o_item.edge_time = i_edge_time;
        o_item.last_edge = i_last_edge;
        o_item.is_ref    = !r_have_ref;
        n_have_ref       = r_have_ref;
        if (o_push) begin
            n_have_ref = !i_last_edge;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_ref <= 1'b0;
        end else begin
            r_have_ref <= n_have_ref;
        end
    end

endmodule

### rtl/gcr_etd_queue.sv
module gcr_etd_queue #(
    parameter int DEPTH = 4
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  gcr_etd_pkg::t_edge_item i_item,
    input  logic                    i_pop,
    output logic                    o_full,
    output logic                    o_valid,
    output gcr_etd_pkg::t_edge_item o_item
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    gcr_etd_pkg::t_edge_item r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_do_pop;

    assign o_full   = (r_count == CNT_W'(DEPTH));
    assign o_valid  = (r_count != '0);
    assign o_item   = r_mem[r_rd_ptr];
    assign w_do_pop = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (w_do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (i_push && !w_do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && w_do_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

### rtl/gcr_etd_back.sv
module gcr_etd_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [15:0]             i_bit_period,
    input  logic                    i_head_valid,
    input  gcr_etd_pkg::t_edge_item i_head,
    output logic                    o_pop,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [11:0]             o_value,
    output gcr_etd_pkg::t_status    o_status,
    output gcr_etd_pkg::t_back_stat o_stat
);

    localparam int PB = gcr_etd_pkg::PACKET_BITS;
    localparam int RW = gcr_etd_pkg::RUN_W;

    gcr_etd_pkg::t_back_state r_state, n_state;

    logic [31:0]   r_prev, n_prev;
    logic [RW-1:0] r_bits, n_bits;
    logic          r_level, n_level;
    logic [PB-1:0] r_word, n_word;
    logic          r_stopped, n_stopped;
    logic [31:0]   r_time, n_time;
    logic          r_last, n_last;
    logic [31:0]   r_num, n_num;
    logic [PB-1:0] r_rem, n_rem;
    logic [RW-1:0] r_quo, n_quo;
    logic [2:0]    r_step, n_step;

    logic                 r_out_valid, n_out_valid;
    logic [11:0]          r_value, n_value;
    gcr_etd_pkg::t_status r_status, n_status;

    logic [15:0]   w_period;
    logic [PB-1:0] w_limit;
    logic [PB-1:0] w_divisor;
    logic [RW-1:0] w_remain;
    logic          w_out_free;
    logic          w_big;
    logic          w_run_bad;
    logic          w_load_out;
    logic [15:0]   w_nib;
    logic [3:0]    w_chk;

    assign w_period   = (i_bit_period == '0) ? 16'd1 : i_bit_period;
    // 22 periods: any run at or beyond this is longer than a packet can hold.
    assign w_limit    = (PB'(w_period) << 4) + (PB'(w_period) << 2) + (PB'(w_period) << 1);
    assign w_divisor  = PB'(w_period) << r_step;
    assign w_remain   = RW'(PB) - r_bits;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_big      = (r_num >= {{(32 - PB){1'b0}}, w_limit});
    assign w_run_bad  = (r_quo == '0) || (r_quo > w_remain);

    assign w_nib = {gcr_etd_pkg::gcr_nibble(r_word[19:15]),
                    gcr_etd_pkg::gcr_nibble(r_word[14:10]),
                    gcr_etd_pkg::gcr_nibble(r_word[9:5]),
                    gcr_etd_pkg::gcr_nibble(r_word[4:0])};
    assign w_chk = w_nib[15:12] ^ w_nib[11:8] ^ w_nib[7:4] ^ w_nib[3:0];

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            gcr_etd_pkg::S_IDLE: begin
                if (i_head_valid) begin
                    if (i_head.is_ref || r_stopped || r_bits >= RW'(PB)) begin
                        n_state = i_head.last_edge ? gcr_etd_pkg::S_PAD
                                                   : gcr_etd_pkg::S_IDLE;
                    end else begin
                        n_state = gcr_etd_pkg::S_RANGE;
                    end
                end
            end
            gcr_etd_pkg::S_RANGE: begin
                if (w_big) begin
                    n_state = r_last ? gcr_etd_pkg::S_PAD : gcr_etd_pkg::S_IDLE;
                end else begin
                    n_state = gcr_etd_pkg::S_DIV;
                end
            end
            gcr_etd_pkg::S_DIV: begin
                if (r_step == '0) begin
                    n_state = gcr_etd_pkg::S_APPLY;
                end
            end
            gcr_etd_pkg::S_APPLY: begin
                n_state = r_last ? gcr_etd_pkg::S_PAD : gcr_etd_pkg::S_IDLE;
            end
            gcr_etd_pkg::S_PAD: begin
                n_state = gcr_etd_pkg::S_FIN;
            end
            gcr_etd_pkg::S_FIN: begin
                if (w_out_free) begin
                    n_state = gcr_etd_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = gcr_etd_pkg::S_IDLE;
            end
        endcase
    end

    // Control outputs.
    always_comb begin
        o_pop      = 1'b0;
        w_load_out = 1'b0;
        case (r_state)
            gcr_etd_pkg::S_IDLE: o_pop      = i_head_valid;
            gcr_etd_pkg::S_FIN:  w_load_out = w_out_free;
            default: begin
                o_pop      = 1'b0;
                w_load_out = 1'b0;
            end
        endcase
    end

    // Datapath.
    always_comb begin
        n_prev      = r_prev;
        n_bits      = r_bits;
        n_level     = r_level;
        n_word      = r_word;
        n_stopped   = r_stopped;
        n_time      = r_time;
        n_last      = r_last;
        n_num       = r_num;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_step      = r_step;
        n_out_valid = r_out_valid;
        n_value     = r_value;
        n_status    = r_status;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            gcr_etd_pkg::S_IDLE: begin
                if (i_head_valid) begin
                    n_time = i_head.edge_time;
                    n_last = i_head.last_edge;
                    if (i_head.is_ref) begin
                        n_prev    = i_head.edge_time;
                        n_bits    = '0;
                        n_level   = 1'b0;
                        n_word    = '0;
                        n_stopped = 1'b0;
                    end else if (!r_stopped && r_bits >= RW'(PB)) begin
                        // An edge after a full word ends the packet but keeps it valid.
                        n_stopped = 1'b1;
                    end else if (!r_stopped) begin
                        n_num = i_head.edge_time - r_prev + {17'd0, w_period[15:1]};
                    end
                end
            end
            gcr_etd_pkg::S_RANGE: begin
                if (w_big) begin
                    n_stopped = 1'b1;
                end else begin
                    n_rem  = r_num[PB-1:0];
                    n_quo  = '0;
                    n_step = 3'(RW - 1);
                end
            end
            gcr_etd_pkg::S_DIV: begin
                // One restoring division step per cycle, quotient bit at r_step.
                if (r_rem >= w_divisor) begin
                    n_rem = r_rem - w_divisor;
                    n_quo = r_quo | (RW'(1) << r_step);
                end
                if (r_step != '0) begin
                    n_step = r_step - 3'd1;
                end
            end
            gcr_etd_pkg::S_APPLY: begin
                if (w_run_bad) begin
                    n_stopped = 1'b1;
                end else begin
                    n_word  = gcr_etd_pkg::shift_run(r_word, r_quo);
                    n_bits  = r_bits + r_quo;
                    n_level = !r_level;
                    n_prev  = r_time;
                end
            end
            gcr_etd_pkg::S_PAD: begin
                // A high final run fills the rest of the word.
                if (!r_stopped && r_bits < RW'(PB) && r_level) begin
                    n_word = gcr_etd_pkg::shift_run(r_word, w_remain);
                    n_bits = RW'(PB);
                end
            end
            gcr_etd_pkg::S_FIN: begin
                if (w_load_out) begin
                    n_out_valid = 1'b1;
                    if (r_bits != RW'(PB)) begin
                        n_value  = '0;
                        n_status = gcr_etd_pkg::ST_FRAME;
                    end else if (w_chk != 4'hF) begin
                        n_value  = '0;
                        n_status = gcr_etd_pkg::ST_CHECKSUM;
                    end else begin
                        n_value  = w_nib[15:4];
                        n_status = gcr_etd_pkg::ST_OK;
                    end
                    n_prev    = '0;
                    n_bits    = '0;
                    n_level   = 1'b0;
                    n_word    = '0;
                    n_stopped = 1'b0;
                end
            end
            default: begin
                n_stopped = r_stopped;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gcr_etd_pkg::S_IDLE;
            r_prev      <= '0;
            r_bits      <= '0;
            r_level     <= 1'b0;
            r_word      <= '0;
            r_stopped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_prev      <= n_prev;
            r_bits      <= n_bits;
            r_level     <= n_level;
            r_word      <= n_word;
            r_stopped   <= n_stopped;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_time   <= n_time;
        r_last   <= n_last;
        r_num    <= n_num;
        r_rem    <= n_rem;
        r_quo    <= n_quo;
        r_step   <= n_step;
        r_value  <= n_value;
        r_status <= n_status;
    end

    assign o_out_valid       = r_out_valid;
    assign o_value           = r_value;
    assign o_status          = r_status;
    assign o_stat.state      = r_state;
    assign o_stat.bits_taken = r_bits;

endmodule

### rtl/gcr_edge_telemetry_decoder_unit.sv
// Edge timestamps enter a small queue and are decoded one at a time by the back end.
// A reference edge, or one after the packet stopped or filled, stays in IDLE; a timed edge
// goes through RANGE, the 5-step run-length divider and APPLY, or leaves at RANGE when its
// gap is far too long. A last edge then passes PAD for padding and FIN for the checksum;
// the queue keeps accepting while it has room and a result waits.
// Synchronous active-low reset clears the packet state, the queue and bit_period to 100.
module gcr_edge_telemetry_decoder_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] edge_time
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [11:0] telemetry_value, [15:12] zero
    output logic [1:0]  m_axis_tuser,   // [1:0] status
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    logic [15:0] r_bit_period;

    logic                    w_push;
    logic                    w_q_full;
    logic                    w_q_valid;
    logic                    w_pop;
    gcr_etd_pkg::t_edge_item w_in_item;
    gcr_etd_pkg::t_edge_item w_head;
    logic [11:0]             w_value;
    gcr_etd_pkg::t_status    w_status;
    gcr_etd_pkg::t_back_stat w_stat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_period <= gcr_etd_pkg::BIT_PERIOD_RESET;
        end else if (i_cfg_valid) begin
            r_bit_period <= i_cfg_data;
        end
    end

    gcr_etd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .i_edge_time (s_axis_tdata),
        .i_last_edge (s_axis_tlast),
        .i_q_full    (w_q_full),
        .o_ready     (s_axis_tready),
        .o_push      (w_push),
        .o_item      (w_in_item)
    );

    gcr_etd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_in_item),
        .i_pop   (w_pop),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_item  (w_head)
    );

    gcr_etd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_bit_period (r_bit_period),
        .i_head_valid (w_q_valid),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_value      (w_value),
        .o_status     (w_status),
        .o_stat       (w_stat)
    );

    assign m_axis_tdata = {4'd0, w_value};
    assign m_axis_tuser = w_status;

    // A failed packet never carries a payload.
    a_err_zero_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != gcr_etd_pkg::ST_OK) |-> (m_axis_tdata == 16'd0))
        else $error("error result with nonzero telemetry value");

    // A new result only comes out of the finalization step.
    a_result_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> ($past(w_stat.state) == gcr_etd_pkg::S_FIN))
        else $error("result appeared without finalization");

    // The shift word never holds more bits than one packet.
    a_bits_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.bits_taken <= 5'(gcr_etd_pkg::PACKET_BITS))
        else $error("bit count beyond packet length");

endmodule

### dv/tb_gcr_edge_telemetry_decoder_unit.sv
`timescale 1ns / 100ps

module tb_gcr_edge_telemetry_decoder_unit;

    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_ITEMS = 80;
    // GCR code to nibble, entry n in bits [4n+3:4n]; codes that are not GCR give zero.
    localparam logic [127:0] GCR_TO_NIB = 128'h0C40_1800_7650_3200_FED0_BA90_0000_0000;

    typedef struct {
        logic [11:0]          value;
        gcr_etd_pkg::t_status status;
    } t_telemetry;

    typedef struct {
        logic [31:0]          edge_time;
        bit                   last;
        bit                   typed;
        logic [11:0]          value;
        gcr_etd_pkg::t_status status;
    } t_edge_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // [31:0] edge_time
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;        // [11:0] telemetry_value, [15:12] zero
    logic [1:0]  m_axis_tuser;        // [1:0] status
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data = '0;

    // Decoder state as the block should hold it.
    logic [15:0] bit_period_cfg;
    logic [31:0] anchor_time;
    bit          have_anchor;
    int unsigned bits_filled;
    bit          line_high;
    logic [20:0] gcr_word;
    bit          capture_halted;

    t_telemetry  pending_telemetry[$];
    int          fail_count = 0;
    int          items_sent = 0;
    int          src_idle_pct = 0;
    int          sink_idle_pct = 0;
    int          hold_asked = 0;
    int          hold_served = 0;
    int          hold_left = 0;
    int          quiet_cycles = 0;

    // Clean packet 0x9A2 with a padded final run just below the counter wrap, and error cases.
    t_edge_row directed_edges [25] = '{
        '{32'hFFFF_FFFF, 1'b1, 1'b1, 12'h000, gcr_etd_pkg::ST_FRAME},
        '{32'hFFFF_FF38, 1'b0, 1'b0, 12'h000, gcr_etd_pkg::ST_OK},
        '{32'd49,        1'b0, 1'b0, 12'h000, gcr_etd_pkg::ST_OK},
        '{32'd300,       1'b0, 1'b0, 12'h000, gcr_etd_pkg::ST_OK},
        '{32'd450,       1'b0, 1'b0, 12'h000, gcr_etd_pkg::ST_OK},
        '{32'd650,       1'b0, 1'b0, 12'h000, gcr_etd_pkg::ST_OK},
        '{32'd860,       1'b0, 1'b0, 12'h000, gcr_etd_pkg::ST_OK},
        '{32'd1160,      1'b0, 1'b0, 12'h000, gcr_etd_pkg::ST_OK},
        '{32'd1509,      1'b0, 1'b0, 12'h000, gcr_etd_pkg::ST_OK},
        '{32'd1560,      1'b0, 1'b0, 12'h000, gcr_etd_pkg::ST_OK},
        '{32'd1660,      1'b1, 1'b0, 12'h000, gcr_etd_pkg::ST_OK},
        '{32'd0,         1'b0, 1'b0, 12'h000, gcr_etd_pkg::ST_OK},
        '{32'd49,        1'b0, 1'b0, 12'h000, gcr_etd_pkg::ST_OK},
        '{32'd5000,      1'b1, 1'b1, 12'h000, gcr_etd_pkg::ST_FRAME},
        '{32'd10000,     1'b0, 1'b0, 12'h000, gcr_etd_pkg::ST_OK},
        '{32'd12150,     1'b1, 1'b1, 12'h000, gcr_etd_pkg::ST_FRAME},
        '{32'd20000,     1'b0, 1'b0, 12'h000, gcr_etd_pkg::ST_OK},
        '{32'd22100,     1'b0, 1'b0, 12'h000, gcr_etd_pkg::ST_OK},
        '{32'd22200,     1'b0, 1'b0, 12'h000, gcr_etd_pkg::ST_OK},
        '{32'd22300,     1'b1, 1'b1, 12'h000, gcr_etd_pkg::ST_CHECKSUM},
        '{32'd30000,     1'b0, 1'b0, 12'h000, gcr_etd_pkg::ST_OK},
        '{32'd30200,     1'b0, 1'b0, 12'h000, gcr_etd_pkg::ST_OK},
        '{32'd30500,     1'b1, 1'b1, 12'h000, gcr_etd_pkg::ST_FRAME},
        '{32'd40000,     1'b0, 1'b0, 12'h000, gcr_etd_pkg::ST_OK},
        '{32'd39990,     1'b1, 1'b1, 12'h000, gcr_etd_pkg::ST_FRAME}
    };

    gcr_edge_telemetry_decoder_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic void log_fail(string msg);
        fail_count++;
        if (fail_count <= 10) begin
            $display("%t: %s", $realtime, msg);
        end
    endfunction

    function automatic void clear_capture();
        anchor_time = '0;
        have_anchor = 1'b0;
        bits_filled = 0;
        line_high = 1'b0;
        gcr_word = '0;
        capture_halted = 1'b0;
    endfunction

    function automatic void append_run(int unsigned run);
        logic [31:0] wide;
        wide = ({11'd0, gcr_word} << run) | (32'd1 << (run - 1));
        gcr_word = wide[20:0];
        bits_filled += run;
    endfunction

    // Returns 0 when the edge is ignored because the capture already stopped.
    function automatic bit apply_edge(logic [31:0] t);
        logic [31:0] per;
        logic [31:0] gap;
        logic [31:0] run;
        if (capture_halted) return 1'b0;
        if (bits_filled >= gcr_etd_pkg::PACKET_BITS) begin
            capture_halted = 1'b1;
            return 1'b1;
        end
        per = (bit_period_cfg == 16'd0) ? 32'd1 : {16'd0, bit_period_cfg};
        gap = t - anchor_time;
        run = (gap + (per >> 1)) / per;
        if (run == 0 || run > gcr_etd_pkg::PACKET_BITS - bits_filled) begin
            capture_halted = 1'b1;
            return 1'b1;
        end
        line_high = !line_high;
        append_run(run);
        anchor_time = t;
        return 1'b1;
    endfunction

    function automatic t_telemetry finish_capture();
        t_telemetry  res;
        logic [15:0] nib;
        logic [3:0]  chk;
        if (!capture_halted && bits_filled < gcr_etd_pkg::PACKET_BITS && line_high) begin
            append_run(gcr_etd_pkg::PACKET_BITS - bits_filled);
        end
        res.value = '0;
        if (bits_filled != gcr_etd_pkg::PACKET_BITS) begin
            res.status = gcr_etd_pkg::ST_FRAME;
        end else begin
            nib = {GCR_TO_NIB[gcr_word[19:15]*4 +: 4], GCR_TO_NIB[gcr_word[14:10]*4 +: 4],
                   GCR_TO_NIB[gcr_word[9:5]*4 +: 4], GCR_TO_NIB[gcr_word[4:0]*4 +: 4]};
            chk = nib[15:12] ^ nib[11:8] ^ nib[7:4] ^ nib[3:0];
            if (chk != 4'hF) begin
                res.status = gcr_etd_pkg::ST_CHECKSUM;
            end else begin
                res.status = gcr_etd_pkg::ST_OK;
                res.value = nib[15:4];
            end
        end
        return res;
    endfunction

    function automatic logic [4:0] nibble_to_gcr(logic [3:0] nib);
        logic [4:0] code;
        case (nib)
            4'd0:    code = 5'd25;
            4'd1:    code = 5'd27;
            4'd2:    code = 5'd18;
            4'd3:    code = 5'd19;
            4'd4:    code = 5'd29;
            4'd5:    code = 5'd21;
            4'd6:    code = 5'd22;
            4'd7:    code = 5'd23;
            4'd8:    code = 5'd26;
            4'd12:   code = 5'd30;
            default: code = {1'b0, nib};
        endcase
        return code;
    endfunction

    // A timer gap that rounds to the given run length; a negative run asks for any gap.
    function automatic logic [31:0] gap_for(int run);
        longint unsigned per;
        longint unsigned lo;
        longint unsigned hi;
        if (run < 0) return $urandom;
        per = (bit_period_cfg == 16'd0) ? 1 : bit_period_cfg;
        lo = run * per;
        hi = lo + per - 1 - per / 2;
        lo = (lo >= per / 2) ? lo - per / 2 : 0;
        return $urandom_range(32'(hi), 32'(lo));
    endfunction

    task automatic send_edge(input logic [31:0] t, input bit last, input bit fixed_en,
                             input logic [11:0] fixed_value,
                             input gcr_etd_pkg::t_status fixed_status);
        t_telemetry res;
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= t;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (!have_anchor) begin
            clear_capture();
            have_anchor = 1'b1;
            anchor_time = t;
        end else begin
            void'(apply_edge(t));
        end
        items_sent++;
        if (last) begin
            res = finish_capture();
            if (fixed_en) begin
                res.value = fixed_value;
                res.status = fixed_status;
            end
            pending_telemetry.push_back(res);
            clear_capture();
        end
    endtask

    task automatic send_capture();
        int          kind;
        int          prev;
        int          runs[$];
        logic [15:0] nib;
        logic [20:0] word;
        logic [31:0] t;
        kind = int'($urandom_range(99));
        t = $urandom;
        if (kind < 4) begin
            send_edge(t, 1'b1, 1'b0, 12'h000, gcr_etd_pkg::ST_OK);
            return;
        end
        nib[15:4] = 12'($urandom);
        nib[3:0] = ~(nib[15:12] ^ nib[11:8] ^ nib[7:4]);
        if (kind < 16) nib = 16'($urandom);
        word = {1'b1, nibble_to_gcr(nib[15:12]), nibble_to_gcr(nib[11:8]),
                nibble_to_gcr(nib[7:4]), nibble_to_gcr(nib[3:0])};
        if (kind >= 16 && kind < 24) word[19:0] = 20'($urandom);
        // Every one in the word starts a run; the first bit is always one.
        prev = 0;
        for (int pos = 1; pos < gcr_etd_pkg::PACKET_BITS; pos++) begin
            if (word[gcr_etd_pkg::PACKET_BITS - 1 - pos]) begin
                runs.push_back(pos - prev);
                prev = pos;
            end
        end
        runs.push_back(gcr_etd_pkg::PACKET_BITS - prev);
        // With an even run count the line is high in the last run, so padding can supply it.
        if (runs.size() % 2 == 0 && $urandom_range(1)) void'(runs.pop_back());
        if (kind >= 24 && kind < 36) begin
            case ($urandom_range(2))
                0:       runs.insert(int'($urandom_range(runs.size())), 0);
                1:       runs.insert(int'($urandom_range(runs.size())),
                                     int'($urandom_range(40, 22)));
                default: runs.insert(int'($urandom_range(runs.size())), -1);
            endcase
        end else if (kind >= 36 && kind < 44) begin
            repeat ($urandom_range(3, 1)) begin
                if (runs.size() > 1) void'(runs.pop_back());
            end
        end else if (kind >= 44 && kind < 52) begin
            runs.push_back($urandom_range(1) ? int'($urandom_range(3, 1)) : -1);
        end
        send_edge(t, 1'b0, 1'b0, 12'h000, gcr_etd_pkg::ST_OK);
        foreach (runs[k]) begin
            t = t + gap_for(runs[k]);
            send_edge(t, k == runs.size() - 1, 1'b0, 12'h000, gcr_etd_pkg::ST_OK);
        end
    endtask

    // Lets the decoder run dry so that the period register can be changed safely.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_telemetry.size() != 0) @(posedge i_clk);
        repeat (48) @(posedge i_clk);
    endtask

    task automatic write_bit_period(input logic [15:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        bit_period_cfg = value;
    endtask

    always @(posedge i_clk) begin : result_sink
        t_telemetry want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_telemetry.size() == 0) begin
                log_fail($sformatf("result %h status %0d with nothing expected",
                                   m_axis_tdata, m_axis_tuser));
            end else begin
                want = pending_telemetry.pop_front();
                if (m_axis_tdata !== {4'h0, want.value} || m_axis_tuser !== want.status) begin
                    log_fail($sformatf("expected value %h status %0d, got %h status %0d",
                                       want.value, want.status, m_axis_tdata, m_axis_tuser));
                end
            end
        end
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (hold_served != hold_asked) begin
            hold_served <= hold_asked;
            hold_left <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int          target;
        logic [15:0] next_period;
        bit_period_cfg = gcr_etd_pkg::BIT_PERIOD_RESET;
        clear_capture();
        src_idle_pct = 18;
        sink_idle_pct = 79;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_edges[i]) begin
            send_edge(directed_edges[i].edge_time, directed_edges[i].last,
                      directed_edges[i].typed, directed_edges[i].value,
                      directed_edges[i].status);
        end

        for (int ph = 0; ph < 6; ph++) begin
            // Two phases per idling pattern: sender light, then receiver light, then none.
            case (ph / 2)
                0: begin
                    src_idle_pct = 18;
                    sink_idle_pct = 79;
                end
                1: begin
                    src_idle_pct = 79;
                    sink_idle_pct = 18;
                end
                default: begin
                    src_idle_pct = 0;
                    sink_idle_pct = 0;
                end
            endcase
            case (ph)
                0:       next_period = 16'd1;
                1:       next_period = 16'hFFFF;
                2:       next_period = 16'd0;
                3:       next_period = 16'($urandom_range(300, 2));
                4:       next_period = 16'($urandom_range(65535, 1));
                default: next_period = 16'd100;
            endcase
            drain();
            write_bit_period(next_period);
            // The receiver stalls for a long while so the input queue backs up.
            if (ph == 4) hold_asked++;
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target) begin
                send_capture();
            end
        end

        s_axis_tvalid <= 1'b0;
        while (pending_telemetry.size() != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
